/* hdl/fq_pkg.sv */
// Shared types, widths and helpers for the frame-to-quaternion pipeline.
package fq_pkg;

  localparam int FB = 15;
  localparam int IW = 16;
  localparam int MW = ((IW + FB > 2 * IW) ? IW + FB : 2 * IW) + 2;
  localparam int HW = (MW + 1) / 2;
  localparam int RW = 2 * HW;
  localparam int SW = HW + 1;
  localparam int DW = MW + 1;
  localparam int QW = DW - FB;
  localparam int CW = (DW > SW + QW) ? DW : SW + QW;
  localparam int CONV_LAT = 2 + HW + 1 + QW + 1;

  typedef logic signed [IW-1:0] comp_t;
  typedef logic signed [MW-1:0] ent_t;
  typedef logic signed [QW:0]   qv_t;

  localparam ent_t ONE = ent_t'(64'sd1 <<< (2 * FB));
  localparam logic [SW-1:0] S_MIN = SW'(64'd1 << (FB + 1));
  localparam qv_t SAT_HI = qv_t'((64'sd1 <<< (IW - 1)) - 64'sd1);
  localparam qv_t SAT_LO = ~SAT_HI;

  typedef enum logic [1:0] {MAJ_W, MAJ_I, MAJ_J, MAJ_K} major_t;

  typedef struct packed {
    ent_t m00, m01, m02;
    ent_t m10, m11, m12;
    ent_t m20, m21, m22;
  } mat_t;

  function automatic comp_t sat(input qv_t v);
    qv_t r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[IW-1:0];
  endfunction

endpackage

/* hdl/frame_to_quaternion_pair.sv */
// Top level: frame and flipped-frame quaternions from a normal and a curvature direction.
//
// Usage: drive the six Q1.15 inputs and raise start; an item is taken at every
// rising edge with start high and busy low. busy is always low, so one item can
// enter every cycle. Each item gives one result: done is high for exactly one
// cycle with quat_* (frame [n, c, n x c]) and flip_* (frame [n, -c, -(n x c)])
// valid in that cycle. The receiver cannot stall; results must be taken.
// The pipeline holds 3 capture/build stages, 2 branch stages, a 17-stage
// square root (one root bit per stage), one prep stage, a 20-stage divider
// (one quotient bit per stage, three lanes) and an output register.
// Throughput: one item per cycle.
// Reset (rst, synchronous) clears all valid bits; items in flight are dropped.
module frame_to_quaternion_pair (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   normal_x,
  input  logic signed [15:0]   normal_y,
  input  logic signed [15:0]   normal_z,
  input  logic signed [15:0]   curv_x,
  input  logic signed [15:0]   curv_y,
  input  logic signed [15:0]   curv_z,
  output logic                 done,
  output logic signed [15:0]   quat_w,
  output logic signed [15:0]   quat_i,
  output logic signed [15:0]   quat_j,
  output logic signed [15:0]   quat_k,
  output logic signed [15:0]   flip_w,
  output logic signed [15:0]   flip_i,
  output logic signed [15:0]   flip_j,
  output logic signed [15:0]   flip_k
);

  logic m_valid, f_done;
  fq_pkg::mat_t mat_q, mat_f;

  assign busy = 1'b0;

  fq_build u_build (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .nx        (normal_x),
    .ny        (normal_y),
    .nz        (normal_z),
    .cx        (curv_x),
    .cy        (curv_y),
    .cz        (curv_z),
    .out_valid (m_valid),
    .mat_q     (mat_q),
    .mat_f     (mat_f)
  );

  fq_conv u_conv_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .mat       (mat_q),
    .out_valid (done),
    .q_w       (quat_w),
    .q_i       (quat_i),
    .q_j       (quat_j),
    .q_k       (quat_k)
  );

  fq_conv u_conv_f (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .mat       (mat_f),
    .out_valid (f_done),
    .q_w       (flip_w),
    .q_i       (flip_i),
    .q_j       (flip_j),
    .q_k       (flip_k)
  );

  a_pair: assert property (@(posedge clk) disable iff (rst) done == f_done)
    else $error("frame and flipped results out of step");

endmodule

/* hdl/fq_build.sv */
// Input capture and rotation-matrix build for the frame and the flipped frame.
module fq_build (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  fq_pkg::comp_t  nx,
  input  fq_pkg::comp_t  ny,
  input  fq_pkg::comp_t  nz,
  input  fq_pkg::comp_t  cx,
  input  fq_pkg::comp_t  cy,
  input  fq_pkg::comp_t  cz,
  output logic           out_valid,
  output fq_pkg::mat_t   mat_q,
  output fq_pkg::mat_t   mat_f
);

  logic v1, v2;
  fq_pkg::comp_t r_nx, r_ny, r_nz, r_cx, r_cy, r_cz;
  fq_pkg::ent_t c_nx, c_ny, c_nz, c_cx, c_cy, c_cz;
  logic signed [2*fq_pkg::IW-1:0] p_nycz, p_nzcy, p_nzcx, p_nxcz, p_nxcy, p_nycx;
  fq_pkg::ent_t x0, x1, x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    r_nx <= nx;
    r_ny <= ny;
    r_nz <= nz;
    r_cx <= cx;
    r_cy <= cy;
    r_cz <= cz;
    c_nx <= fq_pkg::ent_t'(r_nx) <<< fq_pkg::FB;
    c_ny <= fq_pkg::ent_t'(r_ny) <<< fq_pkg::FB;
    c_nz <= fq_pkg::ent_t'(r_nz) <<< fq_pkg::FB;
    c_cx <= fq_pkg::ent_t'(r_cx) <<< fq_pkg::FB;
    c_cy <= fq_pkg::ent_t'(r_cy) <<< fq_pkg::FB;
    c_cz <= fq_pkg::ent_t'(r_cz) <<< fq_pkg::FB;
    p_nycz <= r_ny * r_cz;
    p_nzcy <= r_nz * r_cy;
    p_nzcx <= r_nz * r_cx;
    p_nxcz <= r_nx * r_cz;
    p_nxcy <= r_nx * r_cy;
    p_nycx <= r_ny * r_cx;
  end

  always_comb begin
    x0 = fq_pkg::ent_t'(p_nycz) - fq_pkg::ent_t'(p_nzcy);
    x1 = fq_pkg::ent_t'(p_nzcx) - fq_pkg::ent_t'(p_nxcz);
    x2 = fq_pkg::ent_t'(p_nxcy) - fq_pkg::ent_t'(p_nycx);
  end

  always_ff @(posedge clk) begin
    mat_q.m00 <= c_nx;  mat_q.m01 <= c_cx;  mat_q.m02 <= x0;
    mat_q.m10 <= c_ny;  mat_q.m11 <= c_cy;  mat_q.m12 <= x1;
    mat_q.m20 <= c_nz;  mat_q.m21 <= c_cz;  mat_q.m22 <= x2;
    mat_f.m00 <= c_nx;  mat_f.m01 <= -c_cx; mat_f.m02 <= -x0;
    mat_f.m10 <= c_ny;  mat_f.m11 <= -c_cy; mat_f.m12 <= -x1;
    mat_f.m20 <= c_nz;  mat_f.m21 <= -c_cz; mat_f.m22 <= -x2;
  end

endmodule

/* hdl/fq_conv.sv */
// Pipelined matrix-to-quaternion conversion: branch select, square root, divide, saturate.
module fq_conv (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  fq_pkg::mat_t   mat,
  output logic           out_valid,
  output fq_pkg::comp_t  q_w,
  output fq_pkg::comp_t  q_i,
  output fq_pkg::comp_t  q_j,
  output fq_pkg::comp_t  q_k
);

  localparam int HW = fq_pkg::HW;
  localparam int QW = fq_pkg::QW;
  localparam int RW = fq_pkg::RW;
  localparam int SW = fq_pkg::SW;
  localparam int DW = fq_pkg::DW;
  localparam int CW = fq_pkg::CW;
  localparam int MW = fq_pkg::MW;

  // stage A: trace, radicands, compares, numerators
  fq_pkg::ent_t tr;
  logic a_valid, a_trpos, a_c01, a_c02, a_c12;
  fq_pkg::ent_t a_x0, a_x1, a_x2, a_x3;
  fq_pkg::ent_t a_d0, a_d1, a_d2, a_p0, a_p1, a_p2;

  always_comb begin
    tr = mat.m00 + mat.m11 + mat.m22;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_trpos <= tr > 0;
    a_c01 <= mat.m00 > mat.m11;
    a_c02 <= mat.m00 > mat.m22;
    a_c12 <= mat.m11 > mat.m22;
    a_x0 <= tr + fq_pkg::ONE;
    a_x1 <= fq_pkg::ONE + mat.m00 - mat.m11 - mat.m22;
    a_x2 <= fq_pkg::ONE + mat.m11 - mat.m00 - mat.m22;
    a_x3 <= fq_pkg::ONE + mat.m22 - mat.m00 - mat.m11;
    a_d0 <= mat.m21 - mat.m12;
    a_d1 <= mat.m02 - mat.m20;
    a_d2 <= mat.m10 - mat.m01;
    a_p0 <= mat.m01 + mat.m10;
    a_p1 <= mat.m02 + mat.m20;
    a_p2 <= mat.m12 + mat.m21;
  end

  // stage B: pick the branch
  fq_pkg::major_t b_sel;
  fq_pkg::ent_t b_xs, b_l0, b_l1, b_l2;

  always_comb begin
    if (a_trpos) begin
      b_sel = fq_pkg::MAJ_W;
    end else if (a_c01 && a_c02) begin
      b_sel = fq_pkg::MAJ_I;
    end else if (a_c12) begin
      b_sel = fq_pkg::MAJ_J;
    end else begin
      b_sel = fq_pkg::MAJ_K;
    end
    case (b_sel)
      fq_pkg::MAJ_W: begin
        b_xs = a_x0; b_l0 = a_d0; b_l1 = a_d1; b_l2 = a_d2;
      end
      fq_pkg::MAJ_I: begin
        b_xs = a_x1; b_l0 = a_d0; b_l1 = a_p0; b_l2 = a_p1;
      end
      fq_pkg::MAJ_J: begin
        b_xs = a_x2; b_l0 = a_d1; b_l1 = a_p0; b_l2 = a_p2;
      end
      default: begin
        b_xs = a_x3; b_l0 = a_d2; b_l1 = a_p1; b_l2 = a_p2;
      end
    endcase
    if (b_xs < 0) b_xs = '0;
  end

  // square root pipeline, one root bit per stage
  logic           sq_valid [0:HW];
  logic [HW+1:0]  sq_rem   [0:HW];
  logic [HW-1:0]  sq_root  [0:HW];
  logic [RW-1:0]  sq_x     [0:HW];
  fq_pkg::ent_t   sq_l0    [0:HW];
  fq_pkg::ent_t   sq_l1    [0:HW];
  fq_pkg::ent_t   sq_l2    [0:HW];
  fq_pkg::major_t sq_maj   [0:HW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else begin
      sq_valid[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem[0] <= '0;
    sq_root[0] <= '0;
    sq_x[0] <= RW'($unsigned(b_xs));
    sq_l0[0] <= b_l0;
    sq_l1[0] <= b_l1;
    sq_l2[0] <= b_l2;
    sq_maj[0] <= b_sel;
  end

  for (genvar k = 1; k <= HW; k++) begin : g_sq
    logic [HW+3:0] rtry, trial, diff;
    logic ge;
    always_comb begin
      rtry = {sq_rem[k-1], sq_x[k-1][RW-1 -: 2]};
      trial = {2'b00, sq_root[k-1], 2'b01};
      diff = rtry - trial;
      ge = rtry >= trial;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k] <= 1'b0;
      end else begin
        sq_valid[k] <= sq_valid[k-1];
      end
    end
    always_ff @(posedge clk) begin
      sq_rem[k] <= ge ? diff[HW+1:0] : rtry[HW+1:0];
      sq_root[k] <= {sq_root[k-1][HW-2:0], ge};
      sq_x[k] <= {sq_x[k-1][RW-3:0], 2'b00};
      sq_l0[k] <= sq_l0[k-1];
      sq_l1[k] <= sq_l1[k-1];
      sq_l2[k] <= sq_l2[k-1];
      sq_maj[k] <= sq_maj[k-1];
    end
  end

  // divide prep: S = 2h, major = (h + 1) >> 1, magnitudes plus h for rounding
  logic [HW-1:0] h;
  logic [HW:0]   h_inc;
  logic [MW-1:0] mag0, mag1, mag2;

  always_comb begin
    h = sq_root[HW];
    h_inc = {1'b0, h} + 1'b1;
    mag0 = sq_l0[HW][MW-1] ? $unsigned(-sq_l0[HW]) : $unsigned(sq_l0[HW]);
    mag1 = sq_l1[HW][MW-1] ? $unsigned(-sq_l1[HW]) : $unsigned(sq_l1[HW]);
    mag2 = sq_l2[HW][MW-1] ? $unsigned(-sq_l2[HW]) : $unsigned(sq_l2[HW]);
  end

  logic           dv_valid [0:QW];
  logic [SW-1:0]  dv_s     [0:QW];
  logic [HW-1:0]  dv_majv  [0:QW];
  fq_pkg::major_t dv_maj   [0:QW];
  logic [DW-1:0]  dv_r0    [0:QW];
  logic [DW-1:0]  dv_r1    [0:QW];
  logic [DW-1:0]  dv_r2    [0:QW];
  logic [QW-1:0]  dv_q0    [0:QW];
  logic [QW-1:0]  dv_q1    [0:QW];
  logic [QW-1:0]  dv_q2    [0:QW];
  logic [2:0]     dv_neg   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= sq_valid[HW];
    end
  end

  always_ff @(posedge clk) begin
    dv_s[0] <= {h, 1'b0};
    dv_majv[0] <= h_inc[HW:1];
    dv_maj[0] <= sq_maj[HW];
    dv_r0[0] <= DW'(mag0) + DW'(h);
    dv_r1[0] <= DW'(mag1) + DW'(h);
    dv_r2[0] <= DW'(mag2) + DW'(h);
    dv_q0[0] <= '0;
    dv_q1[0] <= '0;
    dv_q2[0] <= '0;
    dv_neg[0] <= {sq_l2[HW][MW-1], sq_l1[HW][MW-1], sq_l0[HW][MW-1]};
  end

  // restoring division, one quotient bit per stage, three lanes sharing S
  for (genvar k = 1; k <= QW; k++) begin : g_dv
    logic [CW-1:0] sh;
    logic ge0, ge1, ge2;
    always_comb begin
      sh = CW'(dv_s[k-1]) << (QW - k);
      ge0 = CW'(dv_r0[k-1]) >= sh;
      ge1 = CW'(dv_r1[k-1]) >= sh;
      ge2 = CW'(dv_r2[k-1]) >= sh;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k] <= 1'b0;
      end else begin
        dv_valid[k] <= dv_valid[k-1];
      end
    end
    always_ff @(posedge clk) begin
      dv_s[k] <= dv_s[k-1];
      dv_majv[k] <= dv_majv[k-1];
      dv_maj[k] <= dv_maj[k-1];
      dv_neg[k] <= dv_neg[k-1];
      dv_r0[k] <= ge0 ? DW'(CW'(dv_r0[k-1]) - sh) : dv_r0[k-1];
      dv_r1[k] <= ge1 ? DW'(CW'(dv_r1[k-1]) - sh) : dv_r1[k-1];
      dv_r2[k] <= ge2 ? DW'(CW'(dv_r2[k-1]) - sh) : dv_r2[k-1];
      dv_q0[k] <= {dv_q0[k-1][QW-2:0], ge0};
      dv_q1[k] <= {dv_q1[k-1][QW-2:0], ge1};
      dv_q2[k] <= {dv_q2[k-1][QW-2:0], ge2};
    end
  end

  // sign, saturate, place the major component
  fq_pkg::qv_t v0, v1, v2, vm;
  fq_pkg::comp_t s0, s1, s2, sm;

  always_comb begin
    v0 = {1'b0, dv_q0[QW]};
    v1 = {1'b0, dv_q1[QW]};
    v2 = {1'b0, dv_q2[QW]};
    if (dv_neg[QW][0]) v0 = -v0;
    if (dv_neg[QW][1]) v1 = -v1;
    if (dv_neg[QW][2]) v2 = -v2;
    vm = fq_pkg::qv_t'(dv_majv[QW]);
    s0 = fq_pkg::sat(v0);
    s1 = fq_pkg::sat(v1);
    s2 = fq_pkg::sat(v2);
    sm = fq_pkg::sat(vm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    case (dv_maj[QW])
      fq_pkg::MAJ_W: begin
        q_w <= sm; q_i <= s0; q_j <= s1; q_k <= s2;
      end
      fq_pkg::MAJ_I: begin
        q_w <= s0; q_i <= sm; q_j <= s1; q_k <= s2;
      end
      fq_pkg::MAJ_J: begin
        q_w <= s0; q_i <= s1; q_j <= sm; q_k <= s2;
      end
      default: begin
        q_w <= s0; q_i <= s1; q_j <= s2; q_k <= sm;
      end
    endcase
  end

  a_s_min: assert property (@(posedge clk) disable iff (rst)
    dv_valid[0] |-> dv_s[0] >= fq_pkg::S_MIN)
    else $error("divisor below 2.0 at divide entry");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    sq_valid[HW] |-> sq_rem[HW] <= {1'b0, sq_root[HW], 1'b0})
    else $error("square root remainder exceeds 2h");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, fq_pkg::CONV_LAT))
    else $error("result without matching item");

endmodule

/* bench/tb_top.sv */
// Testbench for frame_to_quaternion_pair: random and directed frames checked against a predictor.
module tb_top;

  typedef struct {
    logic signed [15:0] nx, ny, nz, cx, cy, cz;
  } frame_item_t;

  typedef struct {
    logic signed [15:0] q[8];
  } quat_pair_t;

  logic clk, rst, start, busy, done;
  logic signed [15:0] normal_x, normal_y, normal_z, curv_x, curv_y, curv_z;
  logic signed [15:0] quat_w, quat_i, quat_j, quat_k, flip_w, flip_i, flip_j, flip_k;

  frame_item_t pending_items[$];
  quat_pair_t  expected_quats[$];
  int send_idle_pct;
  bit hold_send;
  int errors = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  frame_to_quaternion_pair dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .curv_x(curv_x), .curv_y(curv_y), .curv_z(curv_z),
    .done(done),
    .quat_w(quat_w), .quat_i(quat_i), .quat_j(quat_j), .quat_k(quat_k),
    .flip_w(flip_w), .flip_i(flip_i), .flip_j(flip_j), .flip_k(flip_k)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint rdiv(longint num, longint unsigned den);
    longint unsigned mag, qt;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    qt = (mag + den / 2) / den;
    return (num < 0) ? -longint'(qt) : longint'(qt);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void frame_quat(input longint m[3][3], output logic signed [15:0] o[4]);
    longint one, tr, x, q[4];
    longint unsigned h, s;
    fq_pkg::major_t mj;
    one = 64'sd1 <<< 30;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      mj = fq_pkg::MAJ_W; x = tr + one;
    end else if (m[0][0] > m[1][1] && m[0][0] > m[2][2]) begin
      mj = fq_pkg::MAJ_I; x = one + m[0][0] - m[1][1] - m[2][2];
    end else if (m[1][1] > m[2][2]) begin
      mj = fq_pkg::MAJ_J; x = one + m[1][1] - m[0][0] - m[2][2];
    end else begin
      mj = fq_pkg::MAJ_K; x = one + m[2][2] - m[0][0] - m[1][1];
    end
    if (x < 0) x = 0;
    h = isqrt(x);
    s = 2 * h;
    if (s == 0) s = 1;
    case (mj)
      fq_pkg::MAJ_W: begin
        q[1] = rdiv(m[2][1] - m[1][2], s);
        q[2] = rdiv(m[0][2] - m[2][0], s);
        q[3] = rdiv(m[1][0] - m[0][1], s);
      end
      fq_pkg::MAJ_I: begin
        q[0] = rdiv(m[2][1] - m[1][2], s);
        q[2] = rdiv(m[0][1] + m[1][0], s);
        q[3] = rdiv(m[0][2] + m[2][0], s);
      end
      fq_pkg::MAJ_J: begin
        q[0] = rdiv(m[0][2] - m[2][0], s);
        q[1] = rdiv(m[0][1] + m[1][0], s);
        q[3] = rdiv(m[1][2] + m[2][1], s);
      end
      default: begin
        q[0] = rdiv(m[1][0] - m[0][1], s);
        q[1] = rdiv(m[0][2] + m[2][0], s);
        q[2] = rdiv(m[1][2] + m[2][1], s);
      end
    endcase
    q[int'(mj)] = longint'((h + 1) >> 1);
    for (int i = 0; i < 4; i++) o[i] = clamp16(q[i]);
  endfunction

  function automatic quat_pair_t predict_quats(frame_item_t f);
    quat_pair_t p;
    longint m[3][3];
    logic signed [15:0] o[4];
    longint nx, ny, nz, cx, cy, cz;
    nx = f.nx; ny = f.ny; nz = f.nz; cx = f.cx; cy = f.cy; cz = f.cz;
    m[0][0] = nx <<< 15; m[1][0] = ny <<< 15; m[2][0] = nz <<< 15;
    m[0][1] = cx <<< 15; m[1][1] = cy <<< 15; m[2][1] = cz <<< 15;
    m[0][2] = ny * cz - nz * cy;
    m[1][2] = nz * cx - nx * cz;
    m[2][2] = nx * cy - ny * cx;
    frame_quat(m, o);
    for (int i = 0; i < 4; i++) p.q[i] = o[i];
    for (int r = 0; r < 3; r++) begin
      m[r][1] = -m[r][1];
      m[r][2] = -m[r][2];
    end
    frame_quat(m, o);
    for (int i = 0; i < 4; i++) p.q[4 + i] = o[i];
    return p;
  endfunction

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
      default: return 16'(int'($urandom_range(0, 600)) - 300);
    endcase
  endfunction

  // Mostly near-unit orthogonal frames, some raw noise and full-scale extremes.
  function automatic frame_item_t rand_frame();
    frame_item_t f;
    int mode, a, b, sa, sb;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      a = $urandom_range(0, 2);
      b = (a + 1 + $urandom_range(0, 1)) % 3;
      sa = $urandom_range(0, 1) ? 32767 : -32768;
      sb = $urandom_range(0, 1) ? 32767 : -32768;
      f.nx = rand_comp(2); f.ny = rand_comp(2); f.nz = rand_comp(2);
      f.cx = rand_comp(2); f.cy = rand_comp(2); f.cz = rand_comp(2);
      case (a) 0: f.nx = 16'(sa); 1: f.ny = 16'(sa); default: f.nz = 16'(sa); endcase
      case (b) 0: f.cx = 16'(sb); 1: f.cy = 16'(sb); default: f.cz = 16'(sb); endcase
    end else begin
      mode = (mode == 9) ? 1 : 0;
      f.nx = rand_comp(mode); f.ny = rand_comp(mode); f.nz = rand_comp(mode);
      f.cx = rand_comp(mode); f.cy = rand_comp(mode); f.cz = rand_comp(mode);
    end
    return f;
  endfunction

  function automatic frame_item_t mk(int a, int b, int c, int d, int e, int g);
    frame_item_t f;
    f.nx = 16'(a); f.ny = 16'(b); f.nz = 16'(c);
    f.cx = 16'(d); f.cy = 16'(e); f.cz = 16'(g);
    return f;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      {normal_x, normal_y, normal_z, curv_x, curv_y, curv_z} <= '0;
    end else if (start && !busy) begin
      void'(pending_items.pop_front());
      expected_quats.push_back(predict_quats(
        mk(int'(normal_x), int'(normal_y), int'(normal_z),
           int'(curv_x), int'(curv_y), int'(curv_z))));
      if (pending_items.size() > 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct)
      begin
        start <= 1'b1;
        {normal_x, normal_y, normal_z, curv_x, curv_y, curv_z} <=
          {pending_items[0].nx, pending_items[0].ny, pending_items[0].nz,
           pending_items[0].cx, pending_items[0].cy, pending_items[0].cz};
      end else begin
        start <= 1'b0;
      end
    end else if (!start && pending_items.size() > 0 && !hold_send &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      start <= 1'b1;
      {normal_x, normal_y, normal_z, curv_x, curv_y, curv_z} <=
        {pending_items[0].nx, pending_items[0].ny, pending_items[0].nz,
         pending_items[0].cx, pending_items[0].cy, pending_items[0].cz};
    end
  end

  always @(posedge clk) begin
    quat_pair_t e;
    logic signed [15:0] got[8];
    string names[8];
    names = '{"quat_w", "quat_i", "quat_j", "quat_k", "flip_w", "flip_i", "flip_j", "flip_k"};
    if (!rst && done) begin
      got = '{quat_w, quat_i, quat_j, quat_k, flip_w, flip_i, flip_j, flip_k};
      results_seen++;
      if (expected_quats.size() == 0) begin
        $error("result with no item pending");
        errors++;
      end else begin
        e = expected_quats.pop_front();
        for (int i = 0; i < 8; i++)
          if (got[i] !== e.q[i]) begin
            $error("%s expected %0d actual %0d", names[i], e.q[i], got[i]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 2000) begin
      $display("timeout");
      $display("Verification failed");
      $finish;
    end
  end

  task automatic run_phase(int idle_pct, int n);
    send_idle_pct = idle_pct;
    for (int i = 0; i < n; i++) pending_items.push_back(rand_frame());
    wait (pending_items.size() == 0);
  endtask

  initial begin
    rst = 1'b1;
    hold_send = 1'b0;
    send_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    pending_items.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(32767, 0, 0, 0, 32767, 0));
    pending_items.push_back(mk(-32768, 0, 0, 0, -32768, 0));
    pending_items.push_back(mk(0, 32767, 0, 32767, 0, 0));
    pending_items.push_back(mk(0, 0, 32767, 32767, 0, 0));
    pending_items.push_back(mk(0, -32768, 0, 0, 0, 32767));
    pending_items.push_back(mk(0, 0, -32768, 0, 32767, 0));
    pending_items.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768));
    pending_items.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767));
    pending_items.push_back(mk(32767, -32768, 32767, -32768, 32767, -32768));
    pending_items.push_back(mk(-32768, 0, 0, 0, 32767, 0));
    pending_items.push_back(mk(0, 32767, 0, 0, 0, 32767));
    pending_items.push_back(mk(23170, 23170, 0, -23170, 23170, 0));
    pending_items.push_back(mk(-1, -1, -1, -1, -1, -1));
    pending_items.push_back(mk(1, 0, 0, 0, 1, 0));
    pending_items.push_back(mk(0, 0, 0, 0, 0, 32767));
    wait (pending_items.size() == 0);

    run_phase(37, 200);
    hold_send = 1'b1;
    wait (expected_quats.size() == 0);
    hold_send = 1'b0;
    run_phase(80, 200);
    run_phase(0, 200);
    wait (expected_quats.size() == 0);
    repeat (60) @(posedge clk);

    $display("Covered %0d results: directed extremes, all four branches, random frames.",
             results_seen);
    if (errors == 0 && expected_quats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
